// ----- design/sfs_pkg.sv -----
// Shared types, widths and command codes for the sprite frame sequencer.
`timescale 1ns / 1ps
package sfs_pkg;

  localparam int MAX_FRAMES_DEF = 64;

  localparam int CMD_W   = 4;
  localparam int POS_W   = 6;
  localparam int POS_N   = 64;
  localparam int IMG_W   = 16;
  localparam int CNT_W   = 7;
  localparam int DLY_W   = 8;
  localparam int CFG_A_W = 2;
  localparam int CFG_D_W = 8;
  localparam int IN_W    = 40;
  localparam int OUT_W   = 32;

  localparam logic [CMD_W-1:0] CMD_TICK     = 4'd0;
  localparam logic [CMD_W-1:0] CMD_PLAY     = 4'd1;
  localparam logic [CMD_W-1:0] CMD_PAUSE    = 4'd2;
  localparam logic [CMD_W-1:0] CMD_RESUME   = 4'd3;
  localparam logic [CMD_W-1:0] CMD_STOP     = 4'd4;
  localparam logic [CMD_W-1:0] CMD_NEXT     = 4'd5;
  localparam logic [CMD_W-1:0] CMD_PREV     = 4'd6;
  localparam logic [CMD_W-1:0] CMD_SET_POS  = 4'd7;
  localparam logic [CMD_W-1:0] CMD_SET_CD   = 4'd8;
  localparam logic [CMD_W-1:0] CMD_WR_TABLE = 4'd9;

  localparam logic [CFG_A_W-1:0] REG_FRAME_COUNT   = 2'd0;
  localparam logic [CFG_A_W-1:0] REG_LOOP_ENABLE   = 2'd1;
  localparam logic [CFG_A_W-1:0] REG_FRAME_DELAY   = 2'd2;
  localparam logic [CFG_A_W-1:0] REG_DURATION_STEP = 2'd3;

  typedef struct packed {
    logic             tick_adv;
    logic             set_chg;
    logic [POS_W-1:0] pos;
    logic             loaded;
    logic             playing;
    logic             done;
  } ctrl_res_t;

endpackage

// ----- design/sfs_ctrl.sv -----
// Playback control state: frame position, countdown, play and load flags.
`timescale 1ns / 1ps
module sfs_ctrl #(
  parameter int MAX_FRAMES = sfs_pkg::MAX_FRAMES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        go,
  input  logic [sfs_pkg::CMD_W-1:0]   cmd,
  input  logic [sfs_pkg::POS_W-1:0]   fnum,
  input  logic [sfs_pkg::DLY_W-1:0]   cval,
  input  logic [sfs_pkg::CNT_W-1:0]   frame_count,
  input  logic                        loop_enable,
  input  logic [sfs_pkg::DLY_W-1:0]   frame_delay,
  input  logic [sfs_pkg::DLY_W-1:0]   duration_step,
  output sfs_pkg::ctrl_res_t          res,
  output logic [sfs_pkg::POS_W-1:0]   pos_prev
);
  import sfs_pkg::*;

  localparam int LIM_I = (MAX_FRAMES < POS_N) ? MAX_FRAMES : POS_N;
  localparam logic [CNT_W-1:0] LIM = CNT_W'(LIM_I);

  logic             playing_r, playing_nxt;
  logic             loaded_r, loaded_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [DLY_W-1:0] cd_r, cd_nxt;

  logic [CNT_W-1:0] n, nm1, pos7, step7;
  logic [DLY_W-1:0] cd_dec, reload_val;
  logic             tick_adv, set_chg, done;

  always_comb begin
    if (frame_count == '0) n = CNT_W'(1);
    else if (frame_count > LIM) n = LIM;
    else n = frame_count;
    nm1        = n - CNT_W'(1);
    pos7       = {1'b0, pos_r};
    step7      = pos7 + CNT_W'(1);
    cd_dec     = (cd_r > duration_step) ? cd_r - duration_step : '0;
    reload_val = (frame_delay == '0) ? DLY_W'(1) : frame_delay;
  end

  always_comb begin
    playing_nxt = playing_r;
    loaded_nxt  = loaded_r;
    pos_nxt     = pos_r;
    cd_nxt      = cd_r;
    tick_adv    = 1'b0;
    set_chg     = 1'b0;
    done        = 1'b0;
    case (cmd)
      CMD_TICK: begin
        if (playing_r && loaded_r) begin
          if (cd_dec == '0) begin
            tick_adv = 1'b1;
            cd_nxt   = reload_val;
            if (step7 >= n) begin
              done = 1'b1;
              if (loop_enable) begin
                pos_nxt = '0;
              end else begin
                playing_nxt = 1'b0;
                pos_nxt     = nm1[POS_W-1:0];
              end
            end else begin
              pos_nxt = step7[POS_W-1:0];
            end
          end else begin
            cd_nxt = cd_dec;
          end
        end
      end
      CMD_PLAY: begin
        loaded_nxt  = 1'b1;
        pos_nxt     = '0;
        cd_nxt      = reload_val;
        playing_nxt = 1'b1;
      end
      CMD_PAUSE: begin
        playing_nxt = 1'b0;
      end
      CMD_RESUME: begin
        playing_nxt = 1'b1;
      end
      CMD_STOP: begin
        loaded_nxt  = 1'b0;
        playing_nxt = 1'b0;
        pos_nxt     = '0;
      end
      CMD_NEXT: begin
        if (loaded_r) begin
          if (pos7 < nm1) pos_nxt = step7[POS_W-1:0];
          else if (loop_enable) pos_nxt = '0;
          else done = 1'b1;
        end
      end
      CMD_PREV: begin
        if (loaded_r) begin
          if (pos_r != '0) pos_nxt = pos_r - POS_W'(1);
          else if (loop_enable) pos_nxt = nm1[POS_W-1:0];
          else done = 1'b1;
        end
      end
      CMD_SET_POS: begin
        if (loaded_r) begin
          set_chg = (pos_r != fnum);
          pos_nxt = fnum;
        end
      end
      CMD_SET_CD: begin
        cd_nxt = cval;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      playing_r <= 1'b0;
      loaded_r  <= 1'b0;
      pos_r     <= '0;
      cd_r      <= '0;
    end else if (go) begin
      playing_r <= playing_nxt;
      loaded_r  <= loaded_nxt;
      pos_r     <= pos_nxt;
      cd_r      <= cd_nxt;
    end
  end

  always_comb begin
    res.tick_adv = tick_adv;
    res.set_chg  = set_chg;
    res.pos      = pos_nxt;
    res.loaded   = loaded_nxt;
    res.playing  = playing_nxt;
    res.done     = done;
    pos_prev     = pos_r;
  end

`ifndef ASSERT_OFF
  a_tick_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (go && tick_adv) |-> ({1'b0, pos_nxt} < n))
    else $error("tick advance left frame position outside the frame count");
  a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (go && cmd == CMD_STOP) |=> (!loaded_r && !playing_r && pos_r == '0))
    else $error("stop did not clear playback state");
  a_tick_reload: assert property (@(posedge clk) disable iff (!rst_n)
    (go && tick_adv) |=> (cd_r != '0))
    else $error("countdown reloaded to zero on frame advance");
`endif

endmodule

// ----- design/sfs_table.sv -----
// Frame image table: one write port, two registered read ports.
`timescale 1ns / 1ps
module sfs_table #(
  parameter int MAX_FRAMES = sfs_pkg::MAX_FRAMES_DEF
) (
  input  logic                        clk,
  input  logic                        rd_en,
  input  logic                        we,
  input  logic [sfs_pkg::POS_W-1:0]   waddr,
  input  logic [sfs_pkg::IMG_W-1:0]   wdata,
  input  logic [sfs_pkg::POS_W-1:0]   raddr_a,
  input  logic [sfs_pkg::POS_W-1:0]   raddr_b,
  output logic [sfs_pkg::IMG_W-1:0]   rdata_a,
  output logic [sfs_pkg::IMG_W-1:0]   rdata_b
);
  import sfs_pkg::*;

  localparam int SLOT_W = $clog2(MAX_FRAMES);

  logic [IMG_W-1:0]  mem [MAX_FRAMES];
  logic [SLOT_W-1:0] slot_lut [POS_N];
  logic [SLOT_W-1:0] wslot, aslot, bslot;
  logic [IMG_W-1:0]  rdata_a_r, rdata_b_r;

  // frame position to table slot, position modulo table depth
  for (genvar g = 0; g < POS_N; g++) begin : g_slot
    assign slot_lut[g] = SLOT_W'(g % MAX_FRAMES);
  end

  assign wslot = slot_lut[waddr];
  assign aslot = slot_lut[raddr_a];
  assign bslot = slot_lut[raddr_b];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wslot] <= wdata;
    end
    if (rd_en) begin
      // write-then-read order on the same request for port a; port b reads the old entry
      rdata_a_r <= (we && wslot == aslot) ? wdata : mem[aslot];
      rdata_b_r <= mem[bslot];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

// ----- design/sfs_out.sv -----
// Result stage: image compare, last image tracking and output register.
`timescale 1ns / 1ps
module sfs_out (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        a_go,
  input  logic                        b_go,
  input  sfs_pkg::ctrl_res_t          res,
  input  logic [sfs_pkg::IMG_W-1:0]   img_new,
  input  logic [sfs_pkg::IMG_W-1:0]   img_prev,
  output logic                        frame_changed,
  output logic [sfs_pkg::POS_W-1:0]   current_frame,
  output logic [sfs_pkg::IMG_W-1:0]   image_index,
  output logic                        is_playing,
  output logic                        completed
);
  import sfs_pkg::*;

  ctrl_res_t        mid_r;
  logic [IMG_W-1:0] last_img_r, last_img_nxt;
  logic             chg_nxt;
  logic [IMG_W-1:0] img_nxt;

  logic             chg_r, play_r, done_r;
  logic [POS_W-1:0] pos_r;
  logic [IMG_W-1:0] img_r;

  always_ff @(posedge clk) begin
    if (a_go) begin
      mid_r <= res;
    end
  end

  always_comb begin
    if (mid_r.tick_adv) begin
      chg_nxt      = (last_img_r != img_new) || (img_new != img_prev);
      last_img_nxt = img_new;
    end else begin
      chg_nxt      = mid_r.set_chg;
      last_img_nxt = last_img_r;
    end
    img_nxt = mid_r.loaded ? img_new : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_img_r <= '1;
    end else if (b_go) begin
      last_img_r <= last_img_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (b_go) begin
      chg_r  <= chg_nxt;
      pos_r  <= mid_r.pos;
      img_r  <= img_nxt;
      play_r <= mid_r.playing;
      done_r <= mid_r.done;
    end
  end

  assign frame_changed = chg_r;
  assign current_frame = pos_r;
  assign image_index   = img_r;
  assign is_playing    = play_r;
  assign completed     = done_r;

endmodule

// ----- design/sprite_frame_sequencer_core.sv -----
// Top level of the sprite frame sequencer: request stream in, status stream out.
`timescale 1ns / 1ps
// Takes one command request per cycle while the output is not stalled and
// returns one result for each, in order, after it passes the input register, the
// table read register and the result register. The frame table is a memory
// with one write port and two registered read ports: the control state is
// updated while the table is read at the new and previous frame positions,
// and the image compare follows in the next stage. Table entries that were
// never written read back undefined. Configuration writes are always accepted
// and belong only to idle periods.
module sprite_frame_sequencer_core #(
  parameter int MAX_FRAMES = sfs_pkg::MAX_FRAMES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // command[3:0], frame_number[9:4], table_value[25:10], countdown_value[33:26]
  input  logic [sfs_pkg::IN_W-1:0]      in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // frame_changed[0], current_frame[6:1], image_index[22:7], is_playing[23],
  // completed[24]
  output logic [sfs_pkg::OUT_W-1:0]     out_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sfs_pkg::CFG_A_W-1:0]   cfg_index,
  input  logic [sfs_pkg::CFG_D_W-1:0]   cfg_data
);
  import sfs_pkg::*;

  logic a_valid_r, b_valid_r, out_valid_r;
  logic a_go, b_go;

  logic [CMD_W-1:0] cmd_r;
  logic [POS_W-1:0] fnum_r;
  logic [IMG_W-1:0] tval_r;
  logic [DLY_W-1:0] cval_r;

  logic [CNT_W-1:0] frame_count_r;
  logic             loop_enable_r;
  logic [DLY_W-1:0] frame_delay_r;
  logic [DLY_W-1:0] duration_step_r;

  ctrl_res_t        res;
  logic [POS_W-1:0] pos_prev;
  logic [IMG_W-1:0] img_new, img_prev;

  logic             frame_changed, is_playing, completed;
  logic [POS_W-1:0] current_frame;
  logic [IMG_W-1:0] image_index;

  assign b_go      = b_valid_r && (!out_valid_r || out_tready);
  assign a_go      = a_valid_r && (!b_valid_r || b_go);
  assign in_tready = !a_valid_r || a_go;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) a_valid_r <= in_tvalid;
      if (!b_valid_r || b_go) b_valid_r <= a_go;
      if (!out_valid_r || out_tready) out_valid_r <= b_go;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cmd_r  <= in_tdata[3:0];
      fnum_r <= in_tdata[9:4];
      tval_r <= in_tdata[25:10];
      cval_r <= in_tdata[33:26];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r   <= CNT_W'(1);
      loop_enable_r   <= 1'b0;
      frame_delay_r   <= DLY_W'(1);
      duration_step_r <= DLY_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FRAME_COUNT:   frame_count_r   <= cfg_data[CNT_W-1:0];
        REG_LOOP_ENABLE:   loop_enable_r   <= cfg_data[0];
        REG_FRAME_DELAY:   frame_delay_r   <= cfg_data;
        REG_DURATION_STEP: duration_step_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  sfs_ctrl #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .go            (a_go),
    .cmd           (cmd_r),
    .fnum          (fnum_r),
    .cval          (cval_r),
    .frame_count   (frame_count_r),
    .loop_enable   (loop_enable_r),
    .frame_delay   (frame_delay_r),
    .duration_step (duration_step_r),
    .res           (res),
    .pos_prev      (pos_prev)
  );

  sfs_table #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_table (
    .clk     (clk),
    .rd_en   (a_go),
    .we      (a_go && cmd_r == CMD_WR_TABLE),
    .waddr   (fnum_r),
    .wdata   (tval_r),
    .raddr_a (res.pos),
    .raddr_b (pos_prev),
    .rdata_a (img_new),
    .rdata_b (img_prev)
  );

  sfs_out u_out (
    .clk           (clk),
    .rst_n         (rst_n),
    .a_go          (a_go),
    .b_go          (b_go),
    .res           (res),
    .img_new       (img_new),
    .img_prev      (img_prev),
    .frame_changed (frame_changed),
    .current_frame (current_frame),
    .image_index   (image_index),
    .is_playing    (is_playing),
    .completed     (completed)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, completed, is_playing, image_index, current_frame, frame_changed};

`ifndef ASSERT_OFF
  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> a_valid_r)
    else $error("accepted request not held in input stage");
  a_mid_held: assert property (@(posedge clk) disable iff (!rst_n)
    (b_valid_r && !b_go) |=> b_valid_r)
    else $error("stalled table stage request dropped");
  a_stage_advance: assert property (@(posedge clk) disable iff (!rst_n)
    a_go |=> b_valid_r)
    else $error("input stage advanced into nothing");
`endif

endmodule

// ----- sim/tb_sprite_frame_sequencer_core.sv -----
// Self-checking testbench for the sprite frame sequencer core.
`timescale 1ns / 1ps
module tb_sprite_frame_sequencer_core;
  import sfs_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 4'd10;
  localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 4'd15;
  localparam int PIPE_DEPTH = 3;
  localparam int IDLE_LIMIT = 2000;
  localparam int PHASE_REQS = 250;
  localparam int NUM_PHASES = 7;

  typedef struct packed {
    logic [DLY_W-1:0] cd_value;
    logic [IMG_W-1:0] tbl_value;
    logic [POS_W-1:0] fnum;
    logic [CMD_W-1:0] cmd;
  } cmd_req_t;

  typedef struct packed {
    logic             completed;
    logic             is_playing;
    logic [IMG_W-1:0] image_index;
    logic [POS_W-1:0] current_frame;
    logic             frame_changed;
  } frame_status_t;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_BURSTY} rx_pattern_e;

  // Tracks animation state and queues the status expected for each request.
  class anim_status_tracker;
    logic [CNT_W-1:0] frame_count;
    logic             loop_en;
    logic [DLY_W-1:0] frame_delay;
    logic [DLY_W-1:0] dur_step;
    logic             playing;
    logic             loaded;
    logic [POS_W-1:0] pos;
    logic [DLY_W-1:0] countdown;
    logic [IMG_W-1:0] last_image;
    logic [IMG_W-1:0] frame_tbl [POS_N];
    frame_status_t    pending_status [$];
    int               errors;

    function new();
      frame_count = CNT_W'(1);
      loop_en = 1'b0;
      frame_delay = DLY_W'(1);
      dur_step = DLY_W'(1);
      playing = 1'b0;
      loaded = 1'b0;
      pos = '0;
      countdown = '0;
      last_image = '1;
      errors = 0;
      foreach (frame_tbl[i]) frame_tbl[i] = '0;
    endfunction

    function int pending();
      return pending_status.size();
    endfunction

    function int active_frames();
      int n;
      n = int'(frame_count);
      if (n < 1) n = 1;
      if (n > POS_N) n = POS_N;
      return n;
    endfunction

    function void write_reg(logic [CFG_A_W-1:0] idx, logic [CFG_D_W-1:0] data);
      case (idx)
        REG_FRAME_COUNT:   frame_count = data[CNT_W-1:0];
        REG_LOOP_ENABLE:   loop_en = data[0];
        REG_FRAME_DELAY:   frame_delay = data;
        REG_DURATION_STEP: dur_step = data;
        default: ;
      endcase
    endfunction

    function void reload_countdown();
      countdown = (frame_delay == '0) ? 8'd1 : frame_delay;
    endfunction

    function void note_request(cmd_req_t r);
      frame_status_t s;
      int n;
      int p;
      int nxt;
      logic [POS_W-1:0] prev_pos;
      logic [IMG_W-1:0] img;
      n = active_frames();
      p = int'(pos);
      s = '0;
      case (r.cmd)
        CMD_TICK: begin
          if (playing && loaded) begin
            countdown = (countdown > dur_step) ? countdown - dur_step : 8'd0;
            if (countdown == '0) begin
              prev_pos = pos;
              nxt = p + 1;
              if (nxt >= n) begin
                nxt = 0;
                if (!loop_en) begin
                  playing = 1'b0;
                  nxt = n - 1;
                end
                s.completed = 1'b1;
              end
              pos = nxt[POS_W-1:0];
              reload_countdown();
              img = frame_tbl[pos];
              s.frame_changed = (last_image != img) || (img != frame_tbl[prev_pos]);
              last_image = img;
            end
          end
        end
        CMD_PLAY: begin
          loaded = 1'b1;
          pos = '0;
          reload_countdown();
          playing = 1'b1;
        end
        CMD_PAUSE: playing = 1'b0;
        CMD_RESUME: playing = 1'b1;
        CMD_STOP: begin
          loaded = 1'b0;
          playing = 1'b0;
          pos = '0;
        end
        CMD_NEXT: begin
          if (loaded) begin
            if (p < n - 1) pos = pos + POS_W'(1);
            else if (loop_en) pos = '0;
            else s.completed = 1'b1;
          end
        end
        CMD_PREV: begin
          if (loaded) begin
            if (p > 0) pos = pos - POS_W'(1);
            else if (loop_en) pos = POS_W'(n - 1);
            else s.completed = 1'b1;
          end
        end
        CMD_SET_POS: begin
          if (loaded) begin
            s.frame_changed = (pos != r.fnum);
            pos = r.fnum;
          end
        end
        CMD_SET_CD: countdown = r.cd_value;
        CMD_WR_TABLE: frame_tbl[r.fnum] = r.tbl_value;
        default: ;
      endcase
      s.current_frame = pos;
      s.image_index = loaded ? frame_tbl[pos] : '0;
      s.is_playing = playing;
      pending_status.push_back(s);
    endfunction

    task report(string what, int got, int want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      errors++;
    endtask

    task check_status(frame_status_t got);
      frame_status_t want;
      if (pending_status.size() == 0) begin
        report("unrequested status", int'(got), 0);
      end else begin
        want = pending_status.pop_front();
        if (got.frame_changed !== want.frame_changed)
          report("frame_changed", got.frame_changed, want.frame_changed);
        if (got.current_frame !== want.current_frame)
          report("current_frame", got.current_frame, want.current_frame);
        if (got.image_index !== want.image_index)
          report("image_index", got.image_index, want.image_index);
        if (got.is_playing !== want.is_playing)
          report("is_playing", got.is_playing, want.is_playing);
        if (got.completed !== want.completed)
          report("completed", got.completed, want.completed);
      end
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [IN_W-1:0]    in_tdata = '0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [OUT_W-1:0]   out_tdata;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CFG_A_W-1:0] cfg_index = '0;
  logic [CFG_D_W-1:0] cfg_data = '0;

  anim_status_tracker tracker = new();
  rx_pattern_e        rx_pattern = RX_ALWAYS;
  int                 stall_left = 0;
  int                 burst_left = 0;
  int                 idle_cycles = 0;

  sprite_frame_sequencer_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) tracker.write_reg(cfg_index, cfg_data);
      if (in_tvalid && in_tready)
        tracker.note_request(cmd_req_t'(in_tdata[$bits(cmd_req_t)-1:0]));
      if (out_tvalid && out_tready)
        tracker.check_status(frame_status_t'(out_tdata[$bits(frame_status_t)-1:0]));
    end
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      case (rx_pattern)
        RX_ALWAYS: out_tready <= 1'b1;
        RX_RANDOM: out_tready <= ($urandom_range(0, 9) < 7);
        default: begin
          out_tready <= 1'b1;
          if ($urandom_range(0, 15) == 0) stall_left <= $urandom_range(5, 40);
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  task automatic send_req(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] fnum,
                          input logic [IMG_W-1:0] tval, input logic [DLY_W-1:0] cval);
    cmd_req_t r;
    r.cmd = cmd;
    r.fnum = fnum;
    r.tbl_value = tval;
    r.cd_value = cval;
    in_tdata <= IN_W'(r);
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150) : $urandom_range(0, 10);
    end
  endtask

  // sender holds off until every status is back
  task automatic hold_until_empty();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  task automatic drain_idle();
    hold_until_empty();
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  task automatic configure(input logic [7:0] fc, input logic [7:0] lp,
                           input logic [7:0] dly, input logic [7:0] stp);
    logic [CFG_A_W-1:0] idx [4];
    logic [CFG_D_W-1:0] val [4];
    idx = '{REG_FRAME_COUNT, REG_LOOP_ENABLE, REG_FRAME_DELAY, REG_DURATION_STEP};
    val = '{fc, lp, dly, stp};
    cfg_valid <= 1'b1;
    for (int i = 0; i < 4; i++) begin
      cfg_index <= idx[i];
      cfg_data <= val[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic random_req();
    int pick;
    int n;
    logic [CMD_W-1:0] cmd;
    logic [POS_W-1:0] fnum;
    logic [IMG_W-1:0] tval;
    logic [DLY_W-1:0] cval;
    pick = $urandom_range(0, 99);
    n = tracker.active_frames();
    fnum = POS_W'($urandom);
    tval = IMG_W'($urandom);
    cval = DLY_W'($urandom);
    if (pick < 45) cmd = CMD_TICK;
    else if (pick < 51) cmd = CMD_PLAY;
    else if (pick < 55) cmd = CMD_PAUSE;
    else if (pick < 59) cmd = CMD_RESUME;
    else if (pick < 62) cmd = CMD_STOP;
    else if (pick < 68) cmd = CMD_NEXT;
    else if (pick < 74) cmd = CMD_PREV;
    else if (pick < 80) cmd = CMD_SET_POS;
    else if (pick < 86) cmd = CMD_SET_CD;
    else if (pick < 96) cmd = CMD_WR_TABLE;
    else cmd = CMD_SPARE_FIRST + CMD_W'($urandom_range(0, 5));
    if (cmd == CMD_SET_POS && $urandom_range(0, 1) == 1)
      fnum = POS_W'($urandom_range(0, n - 1));
    if (cmd == CMD_SET_CD && $urandom_range(0, 2) != 0) cval = DLY_W'($urandom_range(0, 3));
    // repeated images keep frame_changed low across an advance
    if (cmd == CMD_WR_TABLE && $urandom_range(0, 2) == 0)
      tval = tracker.frame_tbl[$urandom_range(0, POS_N - 1)];
    send_req(cmd, fnum, tval, cval);
  endtask

  initial begin
    logic [IMG_W-1:0] seed_img;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill every table slot so no read ever hits an unwritten entry
    for (int i = 0; i < POS_N; i++) begin
      case (i)
        0: seed_img = 16'h0000;
        1, 2: seed_img = 16'hFFFF;
        default: seed_img = (i % 2 == 1) ? IMG_W'($urandom_range(0, 3)) : IMG_W'($urandom);
      endcase
      send_req(CMD_WR_TABLE, POS_W'(i), seed_img, DLY_W'($urandom));
    end

    // reset settings, starting with nothing loaded
    send_req(CMD_TICK, '0, '0, '0);
    send_req(CMD_NEXT, '0, '0, '0);
    send_req(CMD_PREV, '0, '0, '0);
    send_req(CMD_SET_POS, 6'd63, '0, '0);
    send_req(CMD_RESUME, '0, '0, '0);
    send_req(CMD_TICK, '0, '0, '0);
    send_req(CMD_PLAY, '0, '0, '0);
    send_req(CMD_TICK, '0, '0, '0);
    send_req(CMD_SPARE_LAST, 6'd63, 16'hFFFF, 8'hFF);

    drain_idle();
    configure(8'd4, 8'd1, 8'd0, 8'd255);
    send_req(CMD_PLAY, '0, '0, '0);
    repeat (4) send_req(CMD_TICK, '0, '0, '0);
    send_req(CMD_PREV, '0, '0, '0);
    send_req(CMD_NEXT, '0, '0, '0);
    send_req(CMD_SET_POS, 6'd63, '0, '0);
    send_req(CMD_TICK, '0, '0, '0);
    send_req(CMD_SET_POS, 6'd63, '0, '0);
    send_req(CMD_NEXT, '0, '0, '0);
    send_req(CMD_PAUSE, '0, '0, '0);
    send_req(CMD_TICK, '0, '0, '0);
    send_req(CMD_SET_CD, 6'd63, 16'hFFFF, 8'hFF);
    send_req(CMD_STOP, '0, '0, '0);

    drain_idle();
    configure(8'd3, 8'd0, 8'd255, 8'd0);
    send_req(CMD_PLAY, '0, '0, '0);
    send_req(CMD_SET_POS, 6'd2, '0, '0);
    send_req(CMD_SET_CD, '0, '0, 8'd0);
    send_req(CMD_TICK, '0, '0, '0);
    send_req(CMD_NEXT, '0, '0, '0);
    send_req(CMD_SET_POS, 6'd0, '0, '0);
    send_req(CMD_PREV, '0, '0, '0);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_idle();
      rx_pattern = rx_pattern_e'(ph % 3);
      case (ph)
        0: configure(8'd8, 8'd1, 8'd1, 8'd1);
        1: configure(8'd64, 8'd0, 8'd3, 8'd1);
        2: configure(8'd1, 8'd1, 8'd255, 8'd255);
        3: configure(8'd0, 8'd0, 8'd0, 8'd0);
        4: configure(8'd127, 8'd1, 8'd2, 8'd2);
        5: configure(8'($urandom_range(1, 64)), 8'($urandom_range(0, 1)),
                     8'($urandom_range(0, 6)), 8'($urandom_range(0, 4)));
        default: configure(8'($urandom_range(1, 64)), 8'($urandom_range(0, 1)),
                           8'($urandom), 8'($urandom));
      endcase
      for (int k = 0; k < PHASE_REQS; k++) begin
        if (k == PHASE_REQS / 2) hold_until_empty();
        random_req();
      end
    end

    drain_idle();
    repeat (10) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/sfs_pkg.sv
design/sfs_ctrl.sv
design/sfs_table.sv
design/sfs_out.sv
design/sprite_frame_sequencer_core.sv
sim/tb_sprite_frame_sequencer_core.sv
